FILE: rtl/core/tpvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpvs_pkg;

    // value and stage formats
    localparam int VALUE_BITS  = 24;
    localparam int STAGE_GUARD = 4;
    localparam int STAGE_BITS  = VALUE_BITS + STAGE_GUARD;
    localparam int STAGE_FRAC  = VALUE_BITS;

    // coefficient format, unsigned q0.24
    localparam int COEF_BITS = 24;
    localparam int COEF_FRAC = 24;
    localparam logic [COEF_BITS-1:0] A_COEF      = 24'd1174405;
    localparam logic [COEF_BITS-1:0] COEFF_RESET = 24'd69905;

    // shared multiplier widths
    localparam int MULA_BITS = STAGE_BITS + 2;
    localparam int MULB_BITS = COEF_BITS + 1;
    localparam int PROD_BITS = MULA_BITS + MULB_BITS;
    localparam int RND_BITS  = PROD_BITS - COEF_FRAC;
    localparam int SUM_BITS  = RND_BITS + 1;

    // snap distance, 0.0001 in stage format
    localparam longint SNAP_LIMIT = ((longint'(1) << STAGE_FRAC) + 5000) / 10000;

    // configuration port
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_INDEX_BITS = CFG_ADDR_BITS - 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTHING_COEFF = 1'b0;

    typedef enum logic [1:0] {
        MUL_TGT_A,
        MUL_S2_A,
        MUL_DIFF_W
    } mul_sel_t;

    typedef struct packed {
        logic     start;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     ld_gm;
        logic     ld_diff_err;
        logic     ld_diff_stage;
        logic     upd_one;
        logic     upd_two;
        logic     snap;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        logic block_active;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tpvs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tpvs_ctrl
    import tpvs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       out_free,
    input  wire dp_status_t status,
    output logic            in_ready,
    output dp_cmd_t         cmd
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_MUL_A = 11'b000_0000_0010,
        ST_MUL_B = 11'b000_0000_0100,
        ST_DIFF1 = 11'b000_0000_1000,
        ST_MUL_C = 11'b000_0001_0000,
        ST_UPD1  = 11'b000_0010_0000,
        ST_DIFF2 = 11'b000_0100_0000,
        ST_MUL_D = 11'b000_1000_0000,
        ST_UPD2  = 11'b001_0000_0000,
        ST_SNAP  = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_TGT_A;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TGT_A;
                state_next  = status.block_active ? ST_MUL_B : ST_DONE;
            end
            ST_MUL_B:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_S2_A;
                cmd.ld_gm   = 1'b1;
                state_next  = ST_DIFF1;
            end
            ST_DIFF1:
            begin
                cmd.ld_diff_err = 1'b1;
                state_next      = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DIFF_W;
                state_next  = ST_UPD1;
            end
            ST_UPD1:
            begin
                cmd.upd_one = 1'b1;
                state_next  = ST_DIFF2;
            end
            ST_DIFF2:
            begin
                cmd.ld_diff_stage = 1'b1;
                state_next        = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DIFF_W;
                state_next  = ST_UPD2;
            end
            ST_UPD2:
            begin
                cmd.upd_two = 1'b1;
                state_next  = ST_SNAP;
            end
            ST_SNAP:
            begin
                cmd.snap   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/tpvs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tpvs_datapath
    import tpvs_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic signed [VALUE_BITS-1:0] target,
    input  wire logic                         frame_first,
    input  wire logic                         frame_last,
    input  wire logic                         resync_request,
    input  wire logic        [COEF_BITS-1:0]  smoothing_coeff,
    input  wire dp_cmd_t                      cmd,
    output dp_status_t                        status,
    output logic signed      [VALUE_BITS-1:0] smoothed,
    output logic                              active
);

    localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
        PROD_BITS'(longint'(1) <<< (COEF_FRAC - 1));
    localparam logic signed [STAGE_BITS:0] SNAP_POS = (STAGE_BITS + 1)'(SNAP_LIMIT);
    localparam logic signed [STAGE_BITS:0] SNAP_NEG = -SNAP_POS;
    localparam logic signed [STAGE_BITS:0] OUT_HALF =
        (STAGE_BITS + 1)'(longint'(1) <<< (STAGE_GUARD - 1));

    function automatic logic signed [STAGE_BITS-1:0] sat_stage(
        input logic signed [SUM_BITS-1:0] x
    );
        logic signed [STAGE_BITS-1:0] r;
        if (x[SUM_BITS-1:STAGE_BITS-1] == {(SUM_BITS - STAGE_BITS + 1){x[SUM_BITS-1]}})
        begin
            r = x[STAGE_BITS-1:0];
        end
        else
        begin
            r = {x[SUM_BITS-1], {(STAGE_BITS - 1){~x[SUM_BITS-1]}}};
        end
        return r;
    endfunction

    logic signed [STAGE_BITS-1:0] stage_one_reg;
    logic signed [STAGE_BITS-1:0] stage_two_reg;
    logic                         resync_pending_reg;
    logic                         block_active_reg;
    logic signed [VALUE_BITS-1:0] block_target_reg;
    logic                         last_reg;
    logic                         req_reg;
    logic signed [RND_BITS-1:0]   prod_reg;
    logic signed [STAGE_BITS-1:0] gm_reg;
    logic signed [MULA_BITS-1:0]  diff_reg;

    logic signed [STAGE_BITS-1:0] in_stage;
    logic signed [STAGE_BITS-1:0] tgt_stage;
    logic signed [MULA_BITS-1:0]  mul_a;
    logic signed [MULB_BITS-1:0]  mul_b;
    logic signed [PROD_BITS-1:0]  product;
    logic signed [PROD_BITS-1:0]  product_rnd;
    logic signed [SUM_BITS-1:0]   prod_wide;
    logic signed [SUM_BITS-1:0]   gm_sum;
    logic signed [SUM_BITS-1:0]   s1_sum;
    logic signed [SUM_BITS-1:0]   s2_sum;
    logic signed [MULA_BITS-1:0]  err_diff;
    logic signed [MULA_BITS-1:0]  stage_diff;
    logic signed [STAGE_BITS:0]   snap_diff;
    logic                         snap_near;
    logic signed [STAGE_BITS:0]   out_sum;
    logic signed [VALUE_BITS:0]   out_shift;

    assign in_stage  = {target, {STAGE_GUARD{1'b0}}};
    assign tgt_stage = {block_target_reg, {STAGE_GUARD{1'b0}}};

    // one shared multiplier, rounded to nearest with ties upward
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_TGT_A:
            begin
                mul_a = {{(MULA_BITS - STAGE_BITS){tgt_stage[STAGE_BITS-1]}}, tgt_stage};
                mul_b = {1'b0, A_COEF};
            end
            MUL_S2_A:
            begin
                mul_a = {{(MULA_BITS - STAGE_BITS){stage_two_reg[STAGE_BITS-1]}},
                         stage_two_reg};
                mul_b = {1'b0, A_COEF};
            end
            MUL_DIFF_W:
            begin
                mul_a = diff_reg;
                mul_b = {1'b0, smoothing_coeff};
            end
            default:
            begin
                mul_a = diff_reg;
                mul_b = {1'b0, smoothing_coeff};
            end
        endcase
    end

    assign product     = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    assign product_rnd = product + ROUND_HALF;

    assign prod_wide = {prod_reg[RND_BITS-1], prod_reg};
    assign gm_sum    = {{(SUM_BITS - STAGE_BITS){tgt_stage[STAGE_BITS-1]}}, tgt_stage}
                       + prod_wide;
    assign s1_sum    = {{(SUM_BITS - STAGE_BITS){stage_one_reg[STAGE_BITS-1]}},
                        stage_one_reg} + prod_wide;
    assign s2_sum    = {{(SUM_BITS - STAGE_BITS){stage_two_reg[STAGE_BITS-1]}},
                        stage_two_reg} + prod_wide;

    assign err_diff   = {{(MULA_BITS - STAGE_BITS){gm_reg[STAGE_BITS-1]}}, gm_reg}
                      - {{(MULA_BITS - STAGE_BITS){stage_one_reg[STAGE_BITS-1]}},
                         stage_one_reg}
                      - prod_reg[MULA_BITS-1:0];
    assign stage_diff = {{(MULA_BITS - STAGE_BITS){stage_one_reg[STAGE_BITS-1]}},
                         stage_one_reg}
                      - {{(MULA_BITS - STAGE_BITS){stage_two_reg[STAGE_BITS-1]}},
                         stage_two_reg};

    assign snap_diff = {tgt_stage[STAGE_BITS-1], tgt_stage}
                     - {stage_two_reg[STAGE_BITS-1], stage_two_reg};
    assign snap_near = (snap_diff > SNAP_NEG) && (snap_diff < SNAP_POS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_one_reg      <= '0;
            stage_two_reg      <= '0;
            resync_pending_reg <= 1'b1;
            block_active_reg   <= 1'b0;
            block_target_reg   <= '0;
        end
        else
        begin
            if (cmd.start && frame_first)
            begin
                block_target_reg <= target;
                if (resync_pending_reg)
                begin
                    stage_one_reg      <= in_stage;
                    stage_two_reg      <= in_stage;
                    resync_pending_reg <= 1'b0;
                    block_active_reg   <= 1'b0;
                end
                else
                begin
                    block_active_reg <= (stage_two_reg != in_stage);
                end
            end
            if (cmd.upd_one)
            begin
                stage_one_reg <= sat_stage(s1_sum);
            end
            if (cmd.upd_two)
            begin
                stage_two_reg <= sat_stage(s2_sum);
            end
            if (cmd.snap && last_reg && snap_near)
            begin
                stage_two_reg <= tgt_stage;
            end
            if (cmd.finish && req_reg)
            begin
                resync_pending_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            last_reg <= frame_last;
            req_reg  <= resync_request;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= product_rnd[PROD_BITS-1:COEF_FRAC];
        end
        if (cmd.ld_gm)
        begin
            gm_reg <= sat_stage(gm_sum);
        end
        if (cmd.ld_diff_err)
        begin
            diff_reg <= err_diff;
        end
        else if (cmd.ld_diff_stage)
        begin
            diff_reg <= stage_diff;
        end
    end

    // output rounding from the guard bits, then saturation
    assign out_sum   = {stage_two_reg[STAGE_BITS-1], stage_two_reg} + OUT_HALF;
    assign out_shift = out_sum[STAGE_BITS:STAGE_GUARD];

    always_comb
    begin
        if (out_shift[VALUE_BITS] == out_shift[VALUE_BITS-1])
        begin
            smoothed = out_shift[VALUE_BITS-1:0];
        end
        else
        begin
            smoothed = {out_shift[VALUE_BITS], {(VALUE_BITS - 1){~out_shift[VALUE_BITS]}}};
        end
    end

    assign active              = block_active_reg;
    assign status.block_active = block_active_reg;

endmodule

`default_nettype wire

FILE: rtl/core/two_pole_value_smoother.sv
`timescale 1ns / 1ps
`default_nettype none

// two-pole value smoother: takes one frame item per transfer and returns one
// result per item, stage two of a cascade of two one-pole stages that move
// towards a target in signed q3.20. the target is latched on a frame that
// carries the first-of-block flag; a pending resync (set by a request on any
// earlier frame) loads both stages with it and bypasses the block, as does a
// target that stage two already sits on. on the last frame of a smoothed block
// stage two snaps to the target when within 0.0001. a smoothed item runs four
// products in turn through a single 30x25 multiplier, each followed by its add
// or subtraction (saturated but for the error), then the snap; a bypassed item
// goes from the first product step to the result. the result is registered once
// the result register is free, and the next item is taken after that. one item
// is in work at a time; the result register lets the next item in while a result
// still waits on the output side. the smoothing weight must be written over the
// register port only while the block is idle; the block does not enforce this.
module two_pole_value_smoother
    import tpvs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    // frame input
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [VALUE_BITS-1:0]    s_axis_tdata,   // [23:0] target
    input  wire logic                     s_axis_tlast,   // frame_last
    input  wire logic [1:0]               s_axis_tuser,   // [0] frame_first, [1] resync_request

    // result output
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [VALUE_BITS-1:0]         m_axis_tdata,   // [23:0] smoothed
    output logic                          m_axis_tuser,   // [0] active

    // register port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output logic      [CFG_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    dp_cmd_t    cmd;
    dp_status_t status;

    logic [COEF_BITS-1:0]         coeff_reg;
    logic                         out_valid_reg;
    logic signed [VALUE_BITS-1:0] out_data_reg;
    logic                         out_active_reg;

    logic signed [VALUE_BITS-1:0] dp_smoothed;
    logic                         dp_active;
    logic                         out_free;
    logic                         cfg_hit;

    // register port: zero wait states, word index from paddr above the byte bits
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[CFG_ADDR_BITS-1:2] == REG_SMOOTHING_COEFF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= COEFF_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            coeff_reg <= pwdata[COEF_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_hit)
        begin
            prdata = {{(CFG_DATA_BITS - COEF_BITS){1'b0}}, coeff_reg};
        end
    end

    // sequencer and datapath
    tpvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    tpvs_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .target          (s_axis_tdata),
        .frame_first     (s_axis_tuser[0]),
        .frame_last      (s_axis_tlast),
        .resync_request  (s_axis_tuser[1]),
        .smoothing_coeff (coeff_reg),
        .cmd             (cmd),
        .status          (status),
        .smoothed        (dp_smoothed),
        .active          (dp_active)
    );

    // result register: loads when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg   <= dp_smoothed;
            out_active_reg <= dp_active;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_active_reg;

    // a result is never written over one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || m_axis_tready))
        else $error("result register overwritten");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted while busy");

    // every new result comes from a finished item
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(cmd.finish))
        else $error("result appeared without a finished item");

    // the sequencer is back to taking items right after finishing
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> s_axis_tready)
        else $error("input not ready after finish");

endmodule

`default_nettype wire
